/* rtl/bnf_pkg.sv */
// Shared types, register codes, mode codes and the duty mapping for the
// bumper navigation block. Used by every module under rtl/.
package bnf_pkg;

  localparam int TIME_BITS = 32;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS = 16;

  // Navigation modes.
  localparam logic [2:0] MODE_PLAN      = 3'd0;
  localparam logic [2:0] MODE_FOLLOW    = 3'd1;
  localparam logic [2:0] MODE_REVERSE   = 3'd2;
  localparam logic [2:0] MODE_ROT_RIGHT = 3'd3;
  localparam logic [2:0] MODE_ROT_LEFT  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FORWARD_DUTY = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REVERSE_DUTY = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROTATE_DUTY  = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_DELAY   = 8'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RESEND_LIMIT = 8'd4;

  // Reset values of the configuration registers.
  localparam logic [15:0] FORWARD_DUTY_RST = 16'd36000;
  localparam logic [15:0] REVERSE_DUTY_RST = 16'd35000;
  localparam logic [15:0] ROTATE_DUTY_RST  = 16'd35000;
  localparam logic [15:0] TURN_DELAY_RST   = 16'd50;
  localparam logic [7:0]  RESEND_LIMIT_RST = 8'd50;

  typedef struct packed {
    logic left_bumper;
    logic right_bumper;
  } in_t;

  typedef struct packed {
    logic [2:0]  nav_mode;
    logic [15:0] left_magnitude;
    logic        left_ahead;
    logic [15:0] right_magnitude;
    logic        right_ahead;
  } out_t;

  typedef struct packed {
    logic [15:0] forward_duty;
    logic [15:0] reverse_duty;
    logic [15:0] rotate_duty;
    logic [15:0] turn_delay_ticks;
    logic [7:0]  resend_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [16:0] left;
    logic signed [16:0] right;
  } duty_pair_t;

  // Signed wheel duties for a navigation mode.
  function automatic duty_pair_t duty_map(input logic [2:0] mode, input cfg_t cfg);
    duty_pair_t d;
    logic signed [16:0] fwd;
    logic signed [16:0] rev;
    logic signed [16:0] rot;
    fwd = $signed({1'b0, cfg.forward_duty});
    rev = $signed({1'b0, cfg.reverse_duty});
    rot = $signed({1'b0, cfg.rotate_duty});
    d.left = '0;
    d.right = '0;
    case (mode)
      MODE_FOLLOW: begin
        d.left = fwd;
        d.right = fwd;
      end
      MODE_REVERSE: begin
        d.left = -rev;
        d.right = -rev;
      end
      MODE_ROT_RIGHT: begin
        d.left = rot;
        d.right = -rot;
      end
      MODE_ROT_LEFT: begin
        d.left = -rot;
        d.right = rot;
      end
      default: begin
        d.left = '0;
        d.right = '0;
      end
    endcase
    return d;
  endfunction

endpackage

/* rtl/bnf_cfg_regs.sv */
// Configuration register file of the bumper navigation block.
// Depends on bnf_pkg for the register indexes, reset values and cfg_t.
module bnf_cfg_regs
  import bnf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward_duty     <= FORWARD_DUTY_RST;
      cfg.reverse_duty     <= REVERSE_DUTY_RST;
      cfg.rotate_duty      <= ROTATE_DUTY_RST;
      cfg.turn_delay_ticks <= TURN_DELAY_RST;
      cfg.resend_limit     <= RESEND_LIMIT_RST;
    end else if (wr_en) begin
      // Writes to indexes past the last register are dropped.
      case (wr_index)
        CFG_FORWARD_DUTY: cfg.forward_duty     <= wr_data;
        CFG_REVERSE_DUTY: cfg.reverse_duty     <= wr_data;
        CFG_ROTATE_DUTY:  cfg.rotate_duty      <= wr_data;
        CFG_TURN_DELAY:   cfg.turn_delay_ticks <= wr_data;
        CFG_RESEND_LIMIT: cfg.resend_limit     <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/bnf_nav_core.sv */
// Navigation state, tick clock, press times and the per-tick rules.
// Depends on bnf_pkg for the mode codes, structs and duty mapping.
module bnf_nav_core
  import bnf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  in_t  bumpers,
  input  cfg_t cfg,
  output logic emit,
  output out_t result
);

  logic [TIME_BITS-1:0] tick_now;
  logic [TIME_BITS-1:0] left_press_time;
  logic [TIME_BITS-1:0] right_press_time;
  logic [TIME_BITS-1:0] change_time;
  logic [2:0]           mode;
  logic                 delay_armed;
  logic [7:0]           resend_count;
  logic signed [16:0]   sent_left_duty;
  logic signed [16:0]   sent_right_duty;

  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] left_press_time_next;
  logic [TIME_BITS-1:0] right_press_time_next;
  logic [TIME_BITS-1:0] elapsed_left;
  logic [TIME_BITS-1:0] elapsed_right;
  logic [TIME_BITS-1:0] elapsed_change;
  logic [TIME_BITS-1:0] delay_limit;
  logic                 left_aged;
  logic                 right_aged;
  logic                 change_aged;
  logic [2:0]           mode_next;
  logic                 delay_armed_next;
  logic                 mode_changed;
  duty_pair_t           duties;
  logic signed [16:0]   left_neg;
  logic signed [16:0]   right_neg;

  always_comb begin
    now = tick_now + TIME_BITS'(1);
    left_press_time_next  = bumpers.left_bumper  ? now : left_press_time;
    right_press_time_next = bumpers.right_bumper ? now : right_press_time;
    elapsed_left   = now - left_press_time_next;
    elapsed_right  = now - right_press_time_next;
    elapsed_change = now - change_time;
    delay_limit    = TIME_BITS'(cfg.turn_delay_ticks);
    left_aged   = elapsed_left > delay_limit;
    right_aged  = elapsed_right > delay_limit;
    change_aged = elapsed_change > delay_limit;

    mode_next = mode;
    delay_armed_next = delay_armed;
    case (mode)
      MODE_REVERSE: begin
        // Turn away from the side that was hit first.
        if (!delay_armed || (left_aged && right_aged)) begin
          mode_next = (elapsed_left > elapsed_right) ? MODE_ROT_RIGHT : MODE_ROT_LEFT;
        end
      end
      MODE_ROT_RIGHT, MODE_ROT_LEFT: begin
        if (!delay_armed || change_aged) begin
          if (!bumpers.left_bumper && !bumpers.right_bumper) begin
            mode_next = MODE_FOLLOW;
          end else if (bumpers.left_bumper && bumpers.right_bumper) begin
            mode_next = MODE_REVERSE;
          end
        end
      end
      MODE_PLAN: begin
        if (resend_count > 8'd1) begin
          mode_next = MODE_FOLLOW;
        end
      end
      MODE_FOLLOW: begin
        if (bumpers.left_bumper && bumpers.right_bumper) begin
          mode_next = MODE_REVERSE;
          delay_armed_next = 1'b1;
        end else if (bumpers.right_bumper) begin
          mode_next = MODE_ROT_LEFT;
          delay_armed_next = 1'b1;
        end else if (bumpers.left_bumper) begin
          mode_next = MODE_ROT_RIGHT;
          delay_armed_next = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_PLAN;
      end
    endcase

    duties = duty_map(mode_next, cfg);
    mode_changed = mode_next != mode;
    emit = (duties.left != sent_left_duty) || (duties.right != sent_right_duty) ||
           mode_changed || (resend_count > cfg.resend_limit);

    left_neg  = -duties.left;
    right_neg = -duties.right;
    result.nav_mode        = mode_next;
    result.left_magnitude  = duties.left[16] ? left_neg[15:0] : duties.left[15:0];
    result.left_ahead      = !duties.left[16] && (duties.left != '0);
    result.right_magnitude = duties.right[16] ? right_neg[15:0] : duties.right[15:0];
    result.right_ahead     = !duties.right[16] && (duties.right != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now         <= '0;
      left_press_time  <= '0;
      right_press_time <= '0;
      change_time      <= '0;
      mode             <= MODE_PLAN;
      delay_armed      <= 1'b0;
      resend_count     <= '0;
      sent_left_duty   <= '0;
      sent_right_duty  <= '0;
    end else if (step) begin
      tick_now         <= now;
      left_press_time  <= left_press_time_next;
      right_press_time <= right_press_time_next;
      mode             <= mode_next;
      delay_armed      <= delay_armed_next;
      if (emit) begin
        sent_left_duty  <= duties.left;
        sent_right_duty <= duties.right;
        resend_count    <= '0;
        if (mode_changed) begin
          change_time <= now;
        end
      end else if (resend_count != 8'hFF) begin
        resend_count <= resend_count + 8'd1;
      end
    end
  end

endmodule

/* rtl/bumper_navigation_fsm.sv */
// Top level of the bumper navigation block: input register, output register
// and assertions. Depends on bnf_pkg, bnf_cfg_regs and bnf_nav_core.
//
// Usage: each word on the input channel (in_valid/in_stall/in_data) is one
// control tick with the two front bumper bits. A tick yields zero or one
// motor command word on the output channel (out_valid/out_stall/out_data):
// a command goes out when the wheel duties or the navigation mode change, or
// when the idle count passes resend_limit.
// An accepted tick waits in the input register; the rules and duty mapping then
// run in one pass into the output register. One tick is accepted per cycle
// while the receiver does not stall; the rate is set by that single pass
// through the navigation state. When the receiver stalls with a command
// waiting, the input register holds one more tick and then in_stall rises
// until the command is taken. Registers are written on the cfg channel
// (cfg_ready is always high); the user must write them only while the block
// is idle, which the block does not enforce. Synchronous reset empties both
// registers, restores the register defaults, zeroes the tick clock and press
// times and puts the block in plan mode; no ticks are lost to a clearing pass.
module bumper_navigation_fsm
  import bnf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_t                       in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_t                      out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t cfg;
  in_t  s1_data;
  logic s1_valid;
  logic hold;
  logic s1_fire;
  logic s1_load;
  logic emit;
  out_t result;

  assign cfg_ready = 1'b1;

  bnf_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The output register is blocked while a command waits on a stalled receiver.
  assign hold     = out_valid && out_stall;
  assign s1_fire  = s1_valid && !hold;
  assign s1_load  = !s1_valid || !hold;
  assign in_stall = s1_valid && hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data <= in_data;
    end
  end

  bnf_nav_core u_nav_core (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_fire),
    .bumpers (s1_data),
    .cfg     (cfg),
    .emit    (emit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= s1_fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      out_data <= result;
    end
  end

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.nav_mode == MODE_PLAN || out_data.nav_mode == MODE_FOLLOW ||
                   out_data.nav_mode == MODE_REVERSE || out_data.nav_mode == MODE_ROT_RIGHT ||
                   out_data.nav_mode == MODE_ROT_LEFT))
    else $error("command carries an unused mode code");

  a_plan_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.nav_mode == MODE_PLAN) |->
      (out_data.left_magnitude == 16'd0 && out_data.right_magnitude == 16'd0))
    else $error("plan mode command drives the wheels");

  a_ahead_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.left_ahead || out_data.right_ahead)) |->
      ((!out_data.left_ahead || out_data.left_magnitude != 16'd0) &&
       (!out_data.right_ahead || out_data.right_magnitude != 16'd0)))
    else $error("forward direction flagged for a zero duty");

  a_reverse_back: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.nav_mode == MODE_REVERSE) |->
      (!out_data.left_ahead && !out_data.right_ahead))
    else $error("reverse command drives a wheel forward");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for bumper_navigation_fsm: directed ticks, then random
// bumper sequences under several register settings, with random gaps and stalls.
// Depends on bnf_pkg and the RTL under rtl/.
module tb;
  import bnf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam in_t BUMP_NONE  = 2'b00;
  localparam in_t BUMP_LEFT  = 2'b10;
  localparam in_t BUMP_RIGHT = 2'b01;
  localparam in_t BUMP_BOTH  = 2'b11;
  localparam int  DRAIN_CYCLES = 6;
  localparam int  PHASES = 8;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  in_t                       in_data;
  logic                      out_valid;
  logic                      out_stall;
  out_t                      out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  bumper_navigation_fsm uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // One row of the directed table: either a register write or a tick, and a
  // tick may carry a hand-written command word in place of the predicted one.
  typedef struct packed {
    logic                      is_cfg;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  val;
    in_t                       bumps;
    logic                      typed;
    out_t                      want;
  } dir_row_t;

  // Predicted navigation state.
  cfg_t               cfg_m;
  logic [31:0]        tick_cnt;
  logic [31:0]        lpress_t;
  logic [31:0]        rpress_t;
  logic [31:0]        mode_change_t;
  logic [2:0]         mode_m;
  logic               armed;
  logic [7:0]         idle_cnt;
  logic signed [16:0] last_l;
  logic signed [16:0] last_r;

  out_t     cmd_q[$];
  out_t     head_cmd;
  dir_row_t dir_tab[$];
  int       errors;
  int       n_ticks;
  int       n_cmds;
  bit       quiet_in;
  bit       quiet_out;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void nav_reset();
    cfg_m = '{FORWARD_DUTY_RST, REVERSE_DUTY_RST, ROTATE_DUTY_RST, TURN_DELAY_RST,
              RESEND_LIMIT_RST};
    tick_cnt = '0;
    lpress_t = '0;
    rpress_t = '0;
    mode_change_t = '0;
    mode_m = MODE_PLAN;
    armed = 1'b0;
    idle_cnt = '0;
    last_l = '0;
    last_r = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      CFG_FORWARD_DUTY: cfg_m.forward_duty = val;
      CFG_REVERSE_DUTY: cfg_m.reverse_duty = val;
      CFG_ROTATE_DUTY:  cfg_m.rotate_duty = val;
      CFG_TURN_DELAY:   cfg_m.turn_delay_ticks = val;
      CFG_RESEND_LIMIT: cfg_m.resend_limit = val[7:0];
      default: ;
    endcase
  endfunction

  // Advances the predicted state by one tick; returns 1 when a command goes out.
  function automatic bit nav_predict(input in_t t, output out_t cmd);
    logic [2:0]         prev;
    logic [2:0]         nxt;
    logic signed [16:0] dl;
    logic signed [16:0] dr;
    logic signed [16:0] fwd;
    logic signed [16:0] rev;
    logic signed [16:0] rot;
    logic signed [16:0] al;
    logic signed [16:0] ar;
    logic [31:0]        tl;
    logic [31:0]        tr;
    logic [31:0]        since_change;
    logic [31:0]        dly_t;
    prev = mode_m;
    nxt = mode_m;
    cmd = '0;
    tick_cnt = tick_cnt + 32'd1;
    if (t.right_bumper) rpress_t = tick_cnt;
    if (t.left_bumper) lpress_t = tick_cnt;
    tl = tick_cnt - lpress_t;
    tr = tick_cnt - rpress_t;
    since_change = tick_cnt - mode_change_t;
    dly_t = 32'(cfg_m.turn_delay_ticks);
    case (mode_m)
      MODE_REVERSE: begin
        if (!armed || (tl > dly_t && tr > dly_t))
          nxt = (tl > tr) ? MODE_ROT_RIGHT : MODE_ROT_LEFT;
      end
      MODE_ROT_RIGHT, MODE_ROT_LEFT: begin
        if (!armed || since_change > dly_t) begin
          if (!t.left_bumper && !t.right_bumper) nxt = MODE_FOLLOW;
          else if (t.left_bumper && t.right_bumper) nxt = MODE_REVERSE;
        end
      end
      MODE_PLAN: begin
        if (idle_cnt > 8'd1) nxt = MODE_FOLLOW;
      end
      MODE_FOLLOW: begin
        if (t.left_bumper && t.right_bumper) nxt = MODE_REVERSE;
        else if (t.right_bumper) nxt = MODE_ROT_LEFT;
        else if (t.left_bumper) nxt = MODE_ROT_RIGHT;
        if (t.left_bumper || t.right_bumper) armed = 1'b1;
      end
      default: nxt = MODE_PLAN;
    endcase
    mode_m = nxt;

    fwd = $signed({1'b0, cfg_m.forward_duty});
    rev = $signed({1'b0, cfg_m.reverse_duty});
    rot = $signed({1'b0, cfg_m.rotate_duty});
    case (nxt)
      MODE_FOLLOW:    begin dl = fwd;  dr = fwd;  end
      MODE_REVERSE:   begin dl = -rev; dr = -rev; end
      MODE_ROT_RIGHT: begin dl = rot;  dr = -rot; end
      MODE_ROT_LEFT:  begin dl = -rot; dr = rot;  end
      default:        begin dl = '0;   dr = '0;   end
    endcase

    if (dl != last_l || dr != last_r || prev != nxt || idle_cnt > cfg_m.resend_limit) begin
      last_l = dl;
      last_r = dr;
      if (prev != nxt) mode_change_t = tick_cnt;
      idle_cnt = '0;
      al = (dl < 0) ? -dl : dl;
      ar = (dr < 0) ? -dr : dr;
      cmd.nav_mode = nxt;
      cmd.left_magnitude = al[15:0];
      cmd.left_ahead = (dl > 0);
      cmd.right_magnitude = ar[15:0];
      cmd.right_ahead = (dr > 0);
      return 1'b1;
    end
    if (idle_cnt != 8'hFF) idle_cnt = idle_cnt + 8'd1;
    return 1'b0;
  endfunction

  function automatic dir_row_t tick_row(input in_t b);
    dir_row_t r;
    r = '0;
    r.bumps = b;
    return r;
  endfunction

  function automatic dir_row_t cmd_row(input in_t b, input out_t w);
    dir_row_t r;
    r = tick_row(b);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                       input logic [CFG_DATA_BITS-1:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  task automatic send_tick(input in_t d, input bit typed, input out_t want);
    int   gap;
    out_t c;
    bit   fire;
    gap = quiet_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    n_ticks++;
    fire = nav_predict(d, c);
    if (typed) cmd_q.insert(cmd_q.size(), want);
    else if (fire) cmd_q.insert(cmd_q.size(), c);
  endtask

  // A tick can leave no command behind, so the task keeps waiting after the
  // last expected word before the block counts as idle.
  task automatic drain_cmds();
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    drain_cmds();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic config_phase(input int p);
    logic [15:0] fwd;
    logic [15:0] rev;
    logic [15:0] rot;
    logic [15:0] dly;
    logic [7:0]  lim;
    fwd = 16'($urandom_range(0, 65535));
    rev = 16'($urandom_range(0, 65535));
    rot = 16'($urandom_range(0, 65535));
    dly = 16'($urandom_range(0, 15));
    lim = 8'($urandom_range(0, 40));
    case (p)
      0: begin
        dly = '0;
        lim = '0;
      end
      1: begin
        fwd = 16'hFFFF;
        rev = 16'hFFFF;
        rot = 16'hFFFF;
        dly = 16'hFFFF;
        lim = 8'hFF;
      end
      2: begin
        fwd = '0;
        rev = '0;
        rot = '0;
        dly = 16'd1;
        lim = 8'd1;
      end
      3: begin
        fwd = FORWARD_DUTY_RST;
        rev = REVERSE_DUTY_RST;
        rot = ROTATE_DUTY_RST;
        dly = TURN_DELAY_RST;
        lim = RESEND_LIMIT_RST;
      end
      5: dly = 16'($urandom_range(100, 400));
      default: ;
    endcase
    write_reg(CFG_FORWARD_DUTY, fwd);
    write_reg(CFG_REVERSE_DUTY, rev);
    write_reg(CFG_ROTATE_DUTY, rot);
    write_reg(CFG_TURN_DELAY, dly);
    // The upper byte of the resend limit word must be ignored.
    write_reg(CFG_RESEND_LIMIT, {8'($urandom_range(0, 255)), lim});
    write_reg(CFG_INDEX_BITS'($urandom_range(int'(CFG_RESEND_LIMIT) + 1, 255)),
              16'($urandom_range(0, 65535)));
  endtask

  // Idle stretches let the block settle back to follow mode and resend;
  // press runs and noise drive the turns and the reverse direction choice.
  task automatic run_phase(input int n_items);
    int  sent;
    int  kind;
    int  len;
    in_t b;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      len = (kind < 4) ? $urandom_range(1, 60) : $urandom_range(1, 6);
      case (kind)
        0, 1, 2, 3: b = BUMP_NONE;
        4: b = BUMP_LEFT;
        5: b = BUMP_RIGHT;
        6: b = BUMP_BOTH;
        default: b = BUMP_NONE;
      endcase
      for (int k = 0; k < len; k++) begin
        if (kind >= 7) b = in_t'($urandom_range(0, 3));
        send_tick(b, 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Receiver: stalls for a random number of cycles before taking each word.
  initial begin
    int n;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      n = quiet_out ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_cmds++;
      if (cmd_q.size() == 0) begin
        $error("command word with none expected: %p", out_data);
        errors++;
      end else begin
        head_cmd = cmd_q.pop_front();
        check_field("nav_mode", 32'(head_cmd.nav_mode), 32'(out_data.nav_mode));
        check_field("left_magnitude", 32'(head_cmd.left_magnitude),
                    32'(out_data.left_magnitude));
        check_field("left_ahead", 32'(head_cmd.left_ahead), 32'(out_data.left_ahead));
        check_field("right_magnitude", 32'(head_cmd.right_magnitude),
                    32'(out_data.right_magnitude));
        check_field("right_ahead", 32'(head_cmd.right_ahead), 32'(out_data.right_ahead));
      end
    end
  end

  initial begin
    errors = 0;
    n_ticks = 0;
    n_cmds = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    rst = 1'b1;
    in_valid <= 1'b0;
    in_data <= BUMP_NONE;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    nav_reset();

    // Reset defaults first, then a zero delay, the duty extremes and a resend
    // limit of zero and of its maximum.
    dir_tab = '{
      tick_row(BUMP_NONE),
      tick_row(BUMP_NONE),
      cmd_row(BUMP_NONE, '{MODE_FOLLOW, 16'd36000, 1'b1, 16'd36000, 1'b1}),
      tick_row(BUMP_NONE),
      cmd_row(BUMP_LEFT, '{MODE_ROT_RIGHT, 16'd35000, 1'b1, 16'd35000, 1'b0}),
      tick_row(BUMP_BOTH),
      tick_row(BUMP_RIGHT),
      tick_row(BUMP_NONE),
      cfg_row(CFG_TURN_DELAY, 16'd0),
      cfg_row(CFG_RESEND_LIMIT, 16'd0),
      cmd_row(BUMP_BOTH, '{MODE_REVERSE, 16'd35000, 1'b0, 16'd35000, 1'b0}),
      tick_row(BUMP_RIGHT),
      tick_row(BUMP_NONE),
      tick_row(BUMP_NONE),
      tick_row(BUMP_NONE),
      tick_row(BUMP_NONE),
      cfg_row(CFG_FORWARD_DUTY, 16'hFFFF),
      cfg_row(CFG_REVERSE_DUTY, 16'd0),
      cfg_row(CFG_ROTATE_DUTY, 16'hFFFF),
      cmd_row(BUMP_NONE, '{MODE_FOLLOW, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1}),
      cmd_row(BUMP_BOTH, '{MODE_REVERSE, 16'd0, 1'b0, 16'd0, 1'b0}),
      tick_row(BUMP_LEFT),
      tick_row(BUMP_NONE),
      cfg_row(CFG_RESEND_LIMIT, 16'hFF00 | 16'd255),
      cfg_row(CFG_FORWARD_DUTY, 16'd0),
      tick_row(BUMP_NONE),
      tick_row(BUMP_NONE),
      tick_row(BUMP_RIGHT),
      tick_row(BUMP_NONE),
      tick_row(BUMP_BOTH)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].val);
      else send_tick(dir_tab[i].bumps, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      config_phase(p);
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      run_phase((p == 1) ? 150 : 260);
    end

    drain_cmds();
    repeat (10) @(posedge clk);
    $display("Ran %0d ticks through %0d register settings; %0d command words compared.",
             n_ticks, PHASES + 2, n_cmds);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
